// ===== sv/twl_pkg.sv =====
package twl_pkg;

  // Field widths fixed by the interface.
  localparam int IdW = 16;
  localparam int KeyW = 17;
  localparam int TicksW = 16;
  localparam int CountW = 6;

  // Operation codes carried on the op port.
  typedef enum logic [2:0] {
    OP_ADD        = 3'd0,
    OP_LOOKUP     = 3'd1,
    OP_REMOVE     = 3'd2,
    OP_WAKE_JOIN  = 3'd3,
    OP_TICK       = 3'd4,
    OP_WAKE_SEM   = 3'd5,
    OP_WAKE_FIRST = 3'd6
  } op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SCAN,
    ST_STATUS
  } state_t;

  // One table entry as stored in the memory.
  typedef struct packed {
    logic [IdW-1:0]    thread;
    logic [IdW-1:0]    sem;
    logic [KeyW-1:0]   join_id;
    logic              timed;
    logic [TicksW-1:0] ticks;
  } slot_entry_t;

  // Verdict on one entry for the running operation.
  typedef struct packed {
    logic        hit;
    logic        wake;
    slot_entry_t upd;
  } eval_t;

endpackage

// ===== sv/twl_table_mem.sv =====
module twl_table_mem #(
  parameter int DEPTH = 32
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [$clog2(DEPTH)-1:0]  waddr,
  input  twl_pkg::slot_entry_t      wdata,
  input  logic                      re,
  input  logic [$clog2(DEPTH)-1:0]  raddr,
  output twl_pkg::slot_entry_t      rdata
);

  twl_pkg::slot_entry_t mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/twl_entry_eval.sv =====
module twl_entry_eval (
  input  twl_pkg::op_t         op,
  input  logic [16:0]          key,
  input  twl_pkg::slot_entry_t entry,
  output twl_pkg::eval_t       res
);

  logic thr_eq;
  logic sem_eq;
  logic join_eq;

  // Stored thread and semaphore ids are zero extended, so a negative key never matches them.
  assign thr_eq  = ({1'b0, entry.thread} == key);
  assign sem_eq  = ({1'b0, entry.sem} == key);
  assign join_eq = (entry.join_id == key);

  // Match and wake decision, plus the countdown for a tick.
  always_comb begin
    res.hit  = 1'b0;
    res.wake = 1'b0;
    res.upd  = entry;
    case (op)
      twl_pkg::OP_LOOKUP,
      twl_pkg::OP_REMOVE:    res.hit = thr_eq;
      twl_pkg::OP_WAKE_FIRST: res.hit = sem_eq;
      twl_pkg::OP_WAKE_JOIN: res.wake = join_eq;
      twl_pkg::OP_WAKE_SEM:  res.wake = sem_eq;
      twl_pkg::OP_TICK: begin
        if (entry.timed) begin
          res.upd.ticks = entry.ticks - 16'd1;
          res.wake = (entry.ticks == 16'd1);
        end
      end
      default: begin
        res.hit = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/thread_wait_list_engine_core.sv =====
// Blocked-thread wait table.
// An operation is accepted at a rising edge with start high and busy low; busy
// then stays high until the operation's status result has been scheduled.
// Results appear on the result ports for one cycle each, marked by strobe. The
// receiver cannot stall, so every result is a transfer in the cycle it shows.
// Each operation gives zero or more woken-thread results and then one status
// result with last high; entry_count on all of them is the count after the op.
// Add and the undefined op go from idle straight to the status state.
// Lookup, remove and wake-first sweep the table once through the memory read
// port. Wake joiners, tick and wake all on a semaphore sweep twice, first
// counting the wakes so every result carries the final count, then
// compacting. The sweep goes over the table memory, one read and one write
// port, one entry per cycle.
// Reset empties the table at once; entry contents are not cleared.
module thread_wait_list_engine_core #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         op,
  input  logic [15:0]        thread_id,
  input  logic [15:0]        sem_id,
  input  logic signed [16:0] join_target,
  input  logic [15:0]        timeout,
  input  logic signed [16:0] search_key,
  output logic               strobe,
  output logic               woken_valid,
  output logic [15:0]        woken_thread,
  output logic               timed_out,
  output logic               found,
  output logic               full_error,
  output logic [5:0]         entry_count,
  output logic               last
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);

  twl_pkg::state_t state, state_next;
  twl_pkg::op_t    op_r;
  logic [16:0]     key_r;
  logic [CW-1:0]   occ;
  logic [CW-1:0]   rd_idx;
  logic [CW-1:0]   w_idx;
  logic [CW-1:0]   wake_cnt;
  logic [CW-1:0]   cnt_final;
  logic            pv;
  logic            found_r;
  logic            full_r;
  logic [15:0]     thr_r;

  logic                 accept;
  logic                 issue;
  logic                 pass_done;
  logic                 take;
  logic                 keep;
  logic                 emit;
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  twl_pkg::slot_entry_t mem_wdata;
  twl_pkg::slot_entry_t mem_rdata;
  twl_pkg::slot_entry_t add_entry;
  twl_pkg::eval_t       ev;

  assign accept    = start && !busy;
  assign busy      = (state != twl_pkg::ST_IDLE);
  assign issue     = ((state == twl_pkg::ST_COUNT) || (state == twl_pkg::ST_SCAN))
                     && (rd_idx < occ);
  assign pass_done = !issue && !pv;

  assign add_entry.thread  = thread_id;
  assign add_entry.sem     = sem_id;
  assign add_entry.join_id = join_target;
  assign add_entry.timed   = (timeout != 16'd0);
  assign add_entry.ticks   = timeout;

  twl_table_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (issue),
    .raddr (rd_idx[IW-1:0]),
    .rdata (mem_rdata)
  );

  twl_entry_eval u_eval (
    .op    (op_r),
    .key   (key_r),
    .entry (mem_rdata),
    .res   (ev)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      twl_pkg::ST_IDLE: begin
        if (accept) begin
          case (twl_pkg::op_t'(op))
            twl_pkg::OP_LOOKUP,
            twl_pkg::OP_REMOVE,
            twl_pkg::OP_WAKE_FIRST: state_next = twl_pkg::ST_SCAN;
            twl_pkg::OP_WAKE_JOIN,
            twl_pkg::OP_TICK,
            twl_pkg::OP_WAKE_SEM:   state_next = twl_pkg::ST_COUNT;
            default:                state_next = twl_pkg::ST_STATUS;
          endcase
        end
      end
      twl_pkg::ST_COUNT:  if (pass_done) state_next = twl_pkg::ST_SCAN;
      twl_pkg::ST_SCAN:   if (pass_done) state_next = twl_pkg::ST_STATUS;
      twl_pkg::ST_STATUS: state_next = twl_pkg::ST_IDLE;
      default:            state_next = twl_pkg::ST_IDLE;
    endcase
  end

  // Per-entry decisions and memory writes.
  always_comb begin
    take      = 1'b0;
    keep      = 1'b1;
    emit      = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = w_idx[IW-1:0];
    mem_wdata = ev.upd;
    case (state)
      twl_pkg::ST_IDLE: begin
        mem_waddr = occ[IW-1:0];
        mem_wdata = add_entry;
        mem_we    = accept && (twl_pkg::op_t'(op) == twl_pkg::OP_ADD)
                    && (occ != CW'(TABLE_DEPTH));
      end
      twl_pkg::ST_SCAN: begin
        if (pv) begin
          case (op_r)
            twl_pkg::OP_LOOKUP: take = ev.hit && !found_r;
            twl_pkg::OP_REMOVE: begin
              take = ev.hit && !found_r;
              keep = !take;
            end
            twl_pkg::OP_WAKE_FIRST: begin
              take = ev.hit && !found_r;
              keep = !take;
              emit = take;
            end
            default: begin
              take = ev.wake;
              keep = !take;
              emit = take;
            end
          endcase
          mem_we = keep;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= twl_pkg::ST_IDLE;
      occ    <= '0;
      pv     <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      pv     <= issue;
      strobe <= emit || (state == twl_pkg::ST_STATUS);
      if (mem_we && (state == twl_pkg::ST_IDLE)) begin
        occ <= occ + CW'(1);
      end
      if ((state == twl_pkg::ST_SCAN) && pass_done) begin
        occ <= w_idx;
      end
    end
  end

  // Operation registers, sweep counters and result fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= twl_pkg::op_t'(op);
      key_r    <= search_key;
      found_r  <= 1'b0;
      full_r   <= (twl_pkg::op_t'(op) == twl_pkg::OP_ADD) && (occ == CW'(TABLE_DEPTH));
      thr_r    <= '0;
      rd_idx   <= '0;
      w_idx    <= '0;
      wake_cnt <= '0;
      cnt_final <= occ - CW'(1);
    end
    if (issue) begin
      rd_idx <= rd_idx + CW'(1);
    end
    if ((state == twl_pkg::ST_COUNT) && pv && ev.wake) begin
      wake_cnt <= wake_cnt + CW'(1);
    end
    if ((state == twl_pkg::ST_COUNT) && pass_done) begin
      rd_idx    <= '0;
      cnt_final <= occ - wake_cnt;
    end
    if (state == twl_pkg::ST_SCAN) begin
      if (take) begin
        found_r <= 1'b1;
        if (op_r == twl_pkg::OP_LOOKUP) begin
          thr_r <= mem_rdata.thread;
        end
      end
      if (mem_we) begin
        w_idx <= w_idx + CW'(1);
      end
    end

    // Result fields for the cycle that follows.
    if (emit) begin
      woken_valid  <= 1'b1;
      woken_thread <= mem_rdata.thread;
      timed_out    <= (op_r == twl_pkg::OP_TICK);
      found        <= 1'b0;
      full_error   <= 1'b0;
      entry_count  <= twl_pkg::CountW'(cnt_final);
      last         <= 1'b0;
    end else begin
      woken_valid  <= 1'b0;
      woken_thread <= thr_r;
      timed_out    <= 1'b0;
      // Only the first-match operations report a match on their status.
      found        <= found_r && ((op_r == twl_pkg::OP_LOOKUP) ||
                                  (op_r == twl_pkg::OP_REMOVE) ||
                                  (op_r == twl_pkg::OP_WAKE_FIRST));
      full_error   <= full_r;
      entry_count  <= twl_pkg::CountW'(occ);
      last         <= 1'b1;
    end
  end

endmodule

// ===== sv/twl_checker.sv =====
module twl_checker #(
  parameter int TABLE_DEPTH = 32
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        strobe,
  input logic        woken_valid,
  input logic        found,
  input logic        full_error,
  input logic [5:0]  entry_count,
  input logic        last
);

  // An accepted operation keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low after an accepted operation");

  // No result transfer in the cycle right after an accept.
  a_no_strobe_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !strobe)
    else $error("result shown right after accept");

  // A woken-thread result never carries status flags.
  a_woken_clean: assert property (@(posedge clk) disable iff (rst)
    (strobe && woken_valid) |-> (!found && !full_error && !last))
    else $error("woken result carries status flags");

  // The reported count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (entry_count <= 6'(TABLE_DEPTH)))
    else $error("entry count beyond table depth");

endmodule

bind thread_wait_list_engine_core twl_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_twl_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .strobe      (strobe),
  .woken_valid (woken_valid),
  .found       (found),
  .full_error  (full_error),
  .entry_count (entry_count),
  .last        (last)
);

// ===== test/tb.sv =====
module tb;

  localparam int Depth = 32;
  localparam int CycleLimit = 600000;

  // One operation waiting to be driven, with its sender idle rate.
  typedef struct {
    twl_pkg::op_t       op;
    logic [15:0]        thread_id;
    logic [15:0]        sem_id;
    logic signed [16:0] join_target;
    logic [15:0]        timeout;
    logic signed [16:0] search_key;
    int                 gap_pct;
    bit                 drain;
  } wait_op_t;

  // One result transfer as the block should present it.
  typedef struct {
    logic        woken_valid;
    logic [15:0] woken_thread;
    logic        timed_out;
    logic        found;
    logic        full_error;
    logic [5:0]  entry_count;
    logic        last;
  } wake_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         op = '0;
  logic [15:0]        thread_id = '0;
  logic [15:0]        sem_id = '0;
  logic signed [16:0] join_target = '0;
  logic [15:0]        timeout = '0;
  logic signed [16:0] search_key = '0;
  logic               strobe;
  logic               woken_valid;
  logic [15:0]        woken_thread;
  logic               timed_out;
  logic               found;
  logic               full_error;
  logic [5:0]         entry_count;
  logic               last;

  wait_op_t     op_queue[$];
  wake_result_t wake_results[$];
  int           errors = 0;
  int           cycles = 0;

  // Shadow copy of the wait table.
  logic [15:0]        tbl_thread[Depth];
  logic [15:0]        tbl_sem[Depth];
  logic signed [16:0] tbl_join[Depth];
  logic               tbl_timed[Depth];
  logic [15:0]        tbl_ticks[Depth];
  int                 tbl_count = 0;

  thread_wait_list_engine_core #(.TABLE_DEPTH(Depth)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .thread_id(thread_id), .sem_id(sem_id), .join_target(join_target),
    .timeout(timeout), .search_key(search_key), .strobe(strobe),
    .woken_valid(woken_valid), .woken_thread(woken_thread), .timed_out(timed_out),
    .found(found), .full_error(full_error), .entry_count(entry_count), .last(last)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("ERROR at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic void move_entry(input int dst, input int src);
    tbl_thread[dst] = tbl_thread[src];
    tbl_sem[dst] = tbl_sem[src];
    tbl_join[dst] = tbl_join[src];
    tbl_timed[dst] = tbl_timed[src];
    tbl_ticks[dst] = tbl_ticks[src];
  endfunction

  // Applies one operation to the shadow table and queues the results it gives.
  function automatic void apply_wait_op(input wait_op_t it);
    wake_result_t woken[$];
    wake_result_t st;
    int i;
    int w;
    bit hit;
    bit wake;
    st = '{default: '0};
    st.last = 1'b1;
    case (it.op)
      twl_pkg::OP_ADD: begin
        if (tbl_count >= Depth) begin
          st.full_error = 1'b1;
        end else begin
          tbl_thread[tbl_count] = it.thread_id;
          tbl_sem[tbl_count] = it.sem_id;
          tbl_join[tbl_count] = it.join_target;
          tbl_timed[tbl_count] = (it.timeout != 0);
          tbl_ticks[tbl_count] = it.timeout;
          tbl_count++;
        end
      end
      twl_pkg::OP_LOOKUP, twl_pkg::OP_REMOVE, twl_pkg::OP_WAKE_FIRST: begin
        hit = 0;
        for (i = 0; i < tbl_count; i++) begin
          if (it.op == twl_pkg::OP_WAKE_FIRST)
            hit = ($signed({1'b0, tbl_sem[i]}) == it.search_key);
          else
            hit = ($signed({1'b0, tbl_thread[i]}) == it.search_key);
          if (hit) break;
        end
        if (hit) begin
          st.found = 1'b1;
          if (it.op == twl_pkg::OP_LOOKUP) begin
            st.woken_thread = tbl_thread[i];
          end else begin
            if (it.op == twl_pkg::OP_WAKE_FIRST)
              woken.push_back('{1'b1, tbl_thread[i], 1'b0, 1'b0, 1'b0, 6'd0, 1'b0});
            for (w = i; w + 1 < tbl_count; w++) move_entry(w, w + 1);
            tbl_count--;
          end
        end
      end
      twl_pkg::OP_WAKE_JOIN, twl_pkg::OP_TICK, twl_pkg::OP_WAKE_SEM: begin
        w = 0;
        for (i = 0; i < tbl_count; i++) begin
          if (it.op == twl_pkg::OP_WAKE_JOIN) begin
            wake = (tbl_join[i] == it.search_key);
          end else if (it.op == twl_pkg::OP_WAKE_SEM) begin
            wake = ($signed({1'b0, tbl_sem[i]}) == it.search_key);
          end else if (!tbl_timed[i]) begin
            wake = 0;
          end else begin
            tbl_ticks[i] = tbl_ticks[i] - 16'd1;
            wake = (tbl_ticks[i] == 0);
          end
          if (wake) begin
            woken.push_back('{1'b1, tbl_thread[i], it.op == twl_pkg::OP_TICK, 1'b0,
                              1'b0, 6'd0, 1'b0});
          end else begin
            if (w != i) move_entry(w, i);
            w++;
          end
        end
        tbl_count = w;
      end
      default: ;
    endcase
    woken.push_back(st);
    foreach (woken[k]) begin
      woken[k].entry_count = tbl_count[5:0];
      wake_results.push_back(woken[k]);
    end
  endfunction

  function automatic wait_op_t make_op(input twl_pkg::op_t code, input int gap);
    wait_op_t it;
    int r;
    it.op = code;
    it.gap_pct = gap;
    it.drain = 0;
    r = $urandom_range(0, 99);
    it.thread_id = (r < 80) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    r = $urandom_range(0, 99);
    it.sem_id = (r < 80) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 30) it.join_target = -17'sd1;
    else if (r < 80) it.join_target = 17'($urandom_range(0, 7));
    else it.join_target = 17'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if (r < 40) it.timeout = 16'd0;
    else if (r < 85) it.timeout = 16'($urandom_range(1, 4));
    else it.timeout = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 15) it.search_key = -17'sd1;
    else if (r < 80) begin
      if (code == twl_pkg::OP_WAKE_SEM || code == twl_pkg::OP_WAKE_FIRST)
        it.search_key = 17'($urandom_range(0, 3));
      else
        it.search_key = 17'($urandom_range(0, 7));
    end else it.search_key = 17'($urandom_range(0, 65535));
    return it;
  endfunction

  function automatic wait_op_t directed_op(input twl_pkg::op_t code,
                                           input logic [15:0] thr,
                                           input logic [15:0] sem,
                                           input logic signed [16:0] jt,
                                           input logic [15:0] tmo,
                                           input logic signed [16:0] key);
    wait_op_t it;
    it = '{code, thr, sem, jt, tmo, key, 0, 0};
    return it;
  endfunction

  // Driver: holds each operation until the block takes it.
  always @(posedge clk) begin
    bit hold;
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start && !busy) begin
        apply_wait_op(op_queue.pop_front());
      end
      hold = (op_queue.size() == 0);
      if (!hold) begin
        hold = ($urandom_range(0, 99) < op_queue[0].gap_pct) ||
               (op_queue[0].drain && wake_results.size() != 0);
      end
      if (hold) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        op <= op_queue[0].op;
        thread_id <= op_queue[0].thread_id;
        sem_id <= op_queue[0].sem_id;
        join_target <= op_queue[0].join_target;
        timeout <= op_queue[0].timeout;
        search_key <= op_queue[0].search_key;
      end
    end
  end

  // Monitor: every strobed result is a transfer and is checked at once.
  always @(posedge clk) begin
    wake_result_t e;
    cycles <= cycles + 1;
    if (!rst && strobe) begin
      if (wake_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        e = wake_results.pop_front();
        if (woken_valid !== e.woken_valid)
          report_mismatch($sformatf("woken_valid %b exp %b", woken_valid, e.woken_valid));
        if (woken_thread !== e.woken_thread)
          report_mismatch($sformatf("woken_thread %h exp %h", woken_thread, e.woken_thread));
        if (timed_out !== e.timed_out)
          report_mismatch($sformatf("timed_out %b exp %b", timed_out, e.timed_out));
        if (found !== e.found)
          report_mismatch($sformatf("found %b exp %b", found, e.found));
        if (full_error !== e.full_error)
          report_mismatch($sformatf("full_error %b exp %b", full_error, e.full_error));
        if (entry_count !== e.entry_count)
          report_mismatch($sformatf("entry_count %0d exp %0d", entry_count, e.entry_count));
        if (last !== e.last)
          report_mismatch($sformatf("last %b exp %b", last, e.last));
      end
    end
    if (cycles > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    wait_op_t it;
    int gap;
    int add_pct;
    int r;
    // Directed: empty table, field extremes and each special case.
    op_queue.push_back(directed_op(twl_pkg::OP_REMOVE, 0, 0, 0, 0, 17'sd5));
    op_queue.push_back(directed_op(twl_pkg::OP_TICK, 0, 0, 0, 0, 0));
    op_queue.push_back(directed_op(twl_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 17'sd65535,
                                   16'hFFFF, -1));
    op_queue.push_back(directed_op(twl_pkg::OP_ADD, 16'h0000, 16'h0000, -17'sd1,
                                   16'd0, 0));
    op_queue.push_back(directed_op(twl_pkg::OP_ADD, 16'h0007, 16'h0002, 17'sd0,
                                   16'd1, 0));
    op_queue.push_back(directed_op(twl_pkg::OP_ADD, 16'h0003, 16'h0000, 17'sd65535,
                                   16'd2, 0));
    op_queue.push_back(directed_op(twl_pkg::OP_LOOKUP, 0, 0, 0, 0, 17'sd65535));
    op_queue.push_back(directed_op(twl_pkg::OP_LOOKUP, 0, 0, 0, 0, -17'sd1));
    op_queue.push_back(directed_op(twl_pkg::OP_LOOKUP, 0, 0, 0, 0, 17'sd1234));
    op_queue.push_back(directed_op(twl_pkg::OP_TICK, 0, 0, 0, 0, 0));
    op_queue.push_back(directed_op(twl_pkg::OP_WAKE_SEM, 0, 0, 0, 0, -17'sd1));
    op_queue.push_back(directed_op(twl_pkg::OP_WAKE_FIRST, 0, 0, 0, 0, 17'sd0));
    op_queue.push_back(directed_op(twl_pkg::OP_WAKE_FIRST, 0, 0, 0, 0, 17'sd9));
    op_queue.push_back(directed_op(twl_pkg::OP_ADD, 16'h0005, 16'h0000, -17'sd1,
                                   16'd0, 0));
    op_queue.push_back(directed_op(twl_pkg::OP_ADD, 16'h0006, 16'h0001, 17'sd65535,
                                   16'd0, 0));
    op_queue.push_back(directed_op(twl_pkg::OP_WAKE_JOIN, 0, 0, 0, 0, -17'sd1));
    op_queue.push_back(directed_op(twl_pkg::OP_WAKE_JOIN, 0, 0, 0, 0, 17'sd65535));
    op_queue.push_back(directed_op(twl_pkg::OP_REMOVE, 0, 0, 0, 0, 17'sd3));
    op_queue.push_back(directed_op(twl_pkg::OP_REMOVE, 0, 0, 0, 0, 17'sd3));
    op_queue.push_back(directed_op(twl_pkg::OP_WAKE_SEM, 0, 0, 0, 0, 17'sd65535));
    op_queue.push_back(directed_op(twl_pkg::OP_WAKE_SEM, 0, 0, 0, 0, 17'sd0));
    // Random: phases of sender idling, with add-heavy stretches to fill the table.
    for (int n = 0; n < 400; n++) begin
      case ((n / 50) % 4)
        0: gap = 0;
        1: gap = 52;
        2: gap = 0;
        default: gap = 23;
      endcase
      add_pct = ((n / 25) % 3 == 1) ? 80 : 35;
      r = $urandom_range(0, 99);
      if (r < add_pct) it = make_op(twl_pkg::OP_ADD, gap);
      else it = make_op(twl_pkg::op_t'($urandom_range(1, 6)), gap);
      it.drain = (n % 97 == 40);
      op_queue.push_back(it);
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (op_queue.size() != 0 || start || wake_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && wake_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== thread_wait_list_engine_core.f =====
sv/twl_pkg.sv
sv/twl_table_mem.sv
sv/twl_entry_eval.sv
sv/thread_wait_list_engine_core.sv
sv/twl_checker.sv
test/tb.sv
